@@ design/anbs_pkg.sv @@
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package anbs_pkg;

    localparam int unsigned HOLD_DEPTH = 4;   // bytes held while a start code may form
    localparam int unsigned MAX_BURST  = 5;   // results one input byte can release
    localparam int unsigned OUTQ_AW_DEF = 3;  // default output queue address width

    localparam logic [31:0] SHORT_TYPES_RESET = 32'h0000_0180; // SPS and PPS
    localparam logic [7:0]  SC_ONE_BYTE  = 8'h01;
    localparam logic [7:0]  SC_ZERO_BYTE = 8'h00;
    localparam logic [1:0]  ZRUN_SHORT   = 2'd2;
    localparam logic [1:0]  ZRUN_LONG    = 2'd3;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic [4:0] nal_type;
        logic       nal_first;
        logic       nal_last;
    } t_result;

    // results released by one input transaction, entry 0 first
    typedef struct packed {
        t_result [MAX_BURST-1:0] res;
        logic [2:0]              cnt;
    } t_burst;

endpackage

`default_nettype wire

@@ design/anbs_parser.sv @@
// Start code matcher and hold buffer for the NAL unit splitter.
// Depends on anbs_pkg; produces one burst of results per input transaction.
`default_nettype none

module anbs_parser
    import anbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_frame_last,
    output t_burst           o_burst
);

    logic [31:0] r_short_types;
    logic [7:0]  r_held [HOLD_DEPTH];
    logic [7:0]  n_held [HOLD_DEPTH];
    logic [2:0]  r_held_cnt,   n_held_cnt;
    logic [1:0]  r_zero_run,   n_zero_run;
    logic        r_inside,     n_inside;
    logic [4:0]  r_region_type, n_region_type;
    logic        r_at_start,   n_at_start;
    logic        r_first_pend, n_first_pend;

    logic [4:0]  rt_eff;
    logic        short_ok;
    logic        is_start;
    logic        is_zero;
    logic [2:0]  keep_cnt;
    logic [2:0]  emit_cnt;
    t_burst      burst;

    always_comb begin
        rt_eff   = r_at_start ? i_byte[4:0] : r_region_type;
        short_ok = r_short_types[rt_eff];
        is_start = !i_frame_last && (i_byte == SC_ONE_BYTE) && (r_zero_run >= ZRUN_SHORT)
                   && ((r_zero_run == ZRUN_LONG) || short_ok);
        is_zero  = !i_frame_last && (i_byte == SC_ZERO_BYTE);
        // data bytes left once the code's zeros are dropped
        keep_cnt = (r_held_cnt >= {1'b0, r_zero_run}) ? r_held_cnt - {1'b0, r_zero_run}
                                                      : 3'd0;
    end

    // result list
    always_comb begin
        for (int j = 0; j < int'(HOLD_DEPTH); j++) begin
            burst.res[j].nal_byte = r_held[j];
        end
        burst.res[MAX_BURST-1].nal_byte = i_byte;
        for (int j = 0; j < int'(MAX_BURST); j++) begin
            burst.res[j].nal_type  = rt_eff;
            burst.res[j].nal_first = 1'b0;
            burst.res[j].nal_last  = 1'b0;
        end
        burst.res[0].nal_first = r_first_pend;

        if (is_start) begin
            emit_cnt = keep_cnt;
            for (int j = 0; j < int'(MAX_BURST); j++) begin
                burst.res[j].nal_last = (3'(j) == keep_cnt - 3'd1);
            end
        end else if (is_zero) begin
            // hold buffer full: oldest byte spills as data
            emit_cnt = (r_held_cnt == 3'(HOLD_DEPTH)) ? 3'd1 : 3'd0;
        end else begin
            emit_cnt = r_held_cnt + {2'b00, i_frame_last};
            burst.res[r_held_cnt].nal_byte = i_byte;
            burst.res[r_held_cnt].nal_last = i_frame_last;
        end

        burst.cnt = (r_inside && i_accept) ? emit_cnt : 3'd0;
    end

    assign o_burst = burst;

    // next state
    always_comb begin
        n_held        = r_held;
        n_held_cnt    = r_held_cnt;
        n_zero_run    = r_zero_run;
        n_inside      = r_inside;
        n_region_type = rt_eff;
        n_at_start    = 1'b0;
        n_first_pend  = r_first_pend && (burst.cnt == 3'd0);

        if (is_start) begin
            n_held_cnt   = 3'd0;
            n_zero_run   = 2'd0;
            n_inside     = 1'b1;
            n_at_start   = 1'b1;
            n_first_pend = 1'b1;
        end else if (is_zero) begin
            if (r_held_cnt == 3'(HOLD_DEPTH)) begin
                for (int j = 0; j < int'(HOLD_DEPTH) - 1; j++) begin
                    n_held[j] = r_held[j+1];
                end
                n_held[HOLD_DEPTH-1] = SC_ZERO_BYTE;
            end else begin
                n_held[r_held_cnt[1:0]] = SC_ZERO_BYTE;
                n_held_cnt = r_held_cnt + 3'd1;
            end
            if (r_zero_run != ZRUN_LONG) begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else if (i_frame_last) begin
            n_held_cnt    = 3'd0;
            n_zero_run    = 2'd0;
            n_inside      = 1'b0;
            n_region_type = 5'd0;
            n_at_start    = 1'b1;
            n_first_pend  = 1'b0;
        end else begin
            n_held[0]  = i_byte;
            n_held_cnt = 3'd1;
            n_zero_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_types <= SHORT_TYPES_RESET;
        end else if (i_cfg_wr_en) begin
            r_short_types <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt    <= 3'd0;
            r_zero_run    <= 2'd0;
            r_inside      <= 1'b0;
            r_region_type <= 5'd0;
            r_at_start    <= 1'b1;
            r_first_pend  <= 1'b0;
        end else if (i_accept) begin
            r_held_cnt    <= n_held_cnt;
            r_zero_run    <= n_zero_run;
            r_inside      <= n_inside;
            r_region_type <= n_region_type;
            r_at_start    <= n_at_start;
            r_first_pend  <= n_first_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= 3'(HOLD_DEPTH))
        else $error("hold count above buffer depth");

    a_zrun_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_zero_run} <= r_held_cnt)
        else $error("zero run longer than held bytes");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_last) |=> (r_held_cnt == 3'd0 && !r_inside && r_at_start))
        else $error("frame end did not restart parser");

endmodule

`default_nettype wire

@@ design/anbs_outq.sv @@
// Output queue for the NAL unit splitter: takes a burst of up to five
// results per cycle and hands them out one per transaction. Depends on anbs_pkg.
`default_nettype none

module anbs_outq
    import anbs_pkg::*;
#(
    parameter int unsigned OUTQ_AW = OUTQ_AW_DEF   // at least 3
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_burst     i_burst,
    output logic            o_room,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_result
);

    localparam int unsigned DEPTH = 1 << OUTQ_AW;

    t_result              r_mem [DEPTH];
    logic [OUTQ_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [OUTQ_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [OUTQ_AW:0]     r_count,  n_count;
    logic                 pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];
    // room for a full burst
    assign o_room   = (r_count <= (OUTQ_AW+1)'(DEPTH - MAX_BURST));

    always_comb begin
        n_wr_ptr = r_wr_ptr + OUTQ_AW'(i_burst.cnt);
        n_rd_ptr = r_rd_ptr + OUTQ_AW'(pop);
        n_count  = r_count + (OUTQ_AW+1)'(i_burst.cnt) - (OUTQ_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < int'(MAX_BURST); j++) begin
            if (3'(j) < i_burst.cnt) begin
                r_mem[r_wr_ptr + OUTQ_AW'(j)] <= i_burst.res[j];
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (OUTQ_AW+1)'(DEPTH))
        else $error("output queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[OUTQ_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ design/annexb_nal_unit_splitter.sv @@
// Top level of the Annex B NAL unit splitter: parser plus output queue.
// Depends on anbs_pkg, anbs_parser and anbs_outq.
//
//  channel   dir  payload                                   handshake
//  s_axis    in   tdata[7:0]=byte_in, tlast=frame_last      tvalid/tready
//  m_axis    out  tdata[7:0]=nal_byte, tuser[4:0]=nal_type,  tvalid/tready
//                 tuser[5]=nal_first, tlast=nal_last
//  cfg       in   i_cfg_wr_data = short_code_types           i_cfg_wr_en
//
// One input byte is taken per ready cycle; its results land in the output queue
// on the same edge and are shown from the next cycle, one per ready cycle.
// s_axis_tready follows queue room for a full burst of five results, so the
// queue depth (1 << OUTQ_AW) sets how far input runs ahead of a stalled output.
// Reset (synchronous, i_rst_n low) empties the queue, restores the short code
// mask to SPS/PPS and returns the parser to before the first start code.
`default_nettype none

module annexb_nal_unit_splitter
    import anbs_pkg::*;
#(
    parameter int unsigned OUTQ_AW = OUTQ_AW_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    // byte stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tlast,   // frame_last
    // NAL unit bytes out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] nal_byte
    output logic [5:0]       m_axis_tuser,   // [4:0] nal_type, [5] nal_first
    output logic             m_axis_tlast    // nal_last
);

    logic    s_accept;
    logic    q_room;
    t_burst  burst;
    t_result q_head;

    assign s_axis_tready = q_room;
    assign s_accept      = s_axis_tvalid && q_room;

    // start code matching, hold buffer, unit marks
    anbs_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (s_accept),
        .i_byte        (s_axis_tdata),
        .i_frame_last  (s_axis_tlast),
        .o_burst       (burst)
    );

    // absorbs bursts at frame end and after zero runs
    anbs_outq #(
        .OUTQ_AW (OUTQ_AW)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_burst  (burst),
        .o_room   (q_room),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (q_head)
    );

    assign m_axis_tdata = q_head.nal_byte;
    assign m_axis_tuser = {q_head.nal_first, q_head.nal_type};
    assign m_axis_tlast = q_head.nal_last;

endmodule

`default_nettype wire
